/* rtl/lng_pkg.sv */
package lng_pkg;

    localparam int LOOKAHEAD_DEPTH = 1024;
    localparam int HOLD_COUNT_BITS = 21;

    localparam int SAMPLE_W     = 16;
    localparam int LEVEL_W      = 16;
    localparam int STEP_W       = 17;
    localparam int HOLD_W       = 20;
    localparam int LOOKAHEAD_W  = 10;
    localparam int GAIN_W       = 17;
    localparam int PEAK_W       = 17;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 20;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_OPEN_THRESHOLD  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CLOSE_THRESHOLD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_STEP     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_STEP    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_SAMPLES    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DECAY_STEP      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_LOOKAHEAD       = 3'd6;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [GAIN_W-1:0]  UNITY_GAIN   = 17'd65536;
    localparam logic [LEVEL_W-1:0] BYPASS_LEVEL = 16'd3;

    typedef struct packed {
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] sample_in;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       last;
    } out_item_t;

endpackage

/* rtl/lookahead_noise_gate.sv */
// Lookahead noise gate.
// Input channel (in_valid / in_stall / in_item): one item per cycle unless stalled.
// A push item stores a sample; once the delay line holds more than the lookahead,
// the oldest sample is gated and leaves as a result. A drain item releases one
// delayed sample per item; the one that empties the line carries last = 1, after
// which the gate state, fill and write pointer return to their reset values.
// Output channel (out_valid / out_stall / out_item): a result is registered in the read
// stage (delay-line read), then goes through the gain multiply into the output
// register. Items that cause no result simply vanish.
// Throughput is one item per clock while not stalled; the delay-line memory takes
// one write and one read per cycle, and the gate state updates once per item.
// When the receiver stalls, the output register holds its item and the read stage
// holds one more; the input is stalled only while both are full.
// Configuration (cfg_we / cfg_index / cfg_data) writes one register per cycle and
// is meant to be used while the block is idle.
// Reset clears all gate state and loads register defaults; the delay-line memory is
// not cleared, since an entry is always written before it is read.
module lookahead_noise_gate #(
    parameter int LOOKAHEAD_DEPTH = lng_pkg::LOOKAHEAD_DEPTH,
    parameter int HOLD_COUNT_BITS = lng_pkg::HOLD_COUNT_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  lng_pkg::in_item_t                   in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output lng_pkg::out_item_t                  out_item,
    input  logic                                cfg_we,
    input  logic [lng_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lng_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int ADDR_W = (LOOKAHEAD_DEPTH > 1) ? $clog2(LOOKAHEAD_DEPTH) : 1;
    localparam int FILL_W = $clog2(LOOKAHEAD_DEPTH + 1);
    localparam int IDX_W  = FILL_W + 1;
    localparam int LA_W   = (FILL_W > lng_pkg::LOOKAHEAD_W) ? FILL_W : lng_pkg::LOOKAHEAD_W;
    localparam int CMP_W  = (HOLD_COUNT_BITS > lng_pkg::HOLD_W) ? HOLD_COUNT_BITS
                                                                 : lng_pkg::HOLD_W;
    localparam int SW     = lng_pkg::SAMPLE_W;
    localparam int GW     = lng_pkg::GAIN_W;
    localparam int PW     = lng_pkg::PEAK_W;
    localparam int LW     = lng_pkg::LEVEL_W;
    localparam int PROD_W = LW + GW;

    // Configuration registers
    logic [LW-1:0]                   open_thr_reg;
    logic [LW-1:0]                   close_thr_reg;
    logic [lng_pkg::STEP_W-1:0]      attack_reg;
    logic [lng_pkg::STEP_W-1:0]      release_reg;
    logic [lng_pkg::HOLD_W-1:0]      hold_reg;
    logic [LW-1:0]                   decay_reg;
    logic [lng_pkg::LOOKAHEAD_W-1:0] lookahead_reg;

    // Gate state
    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic [ADDR_W-1:0]          wp_reg, wp_next;
    logic signed [PW-1:0]       peak_reg, peak_next;
    logic [GW-1:0]              gain_reg, gain_next;
    logic [HOLD_COUNT_BITS-1:0] closed_cnt_reg, closed_cnt_next;
    logic                       gate_open_reg, gate_open_next;
    logic [LW-1:0]              final_mag_reg, final_mag_next;

    // Read stage
    logic                 p_valid_reg;
    logic [GW-1:0]        p_gain_reg;
    logic                 p_bypass_reg;
    logic                 p_fwd_reg;
    logic signed [SW-1:0] p_fwd_sample_reg;
    logic                 p_last_reg;
    logic signed [SW-1:0] rd_data_reg;

    // Output register
    logic                out_valid_reg;
    lng_pkg::out_item_t  out_item_reg;

    logic signed [SW-1:0] mem [LOOKAHEAD_DEPTH];

    logic                 in_accept;
    logic                 advance;
    logic                 is_drain;
    logic signed [SW-1:0] sample;
    logic [LW-1:0]        push_mag;
    logic [LW-1:0]        lvl;
    logic [LA_W-1:0]      la_eff;
    logic [FILL_W-1:0]    fill_inc;
    logic                 take;
    logic [IDX_W-1:0]     wp_ext;
    logic [IDX_W-1:0]     fill_ext;
    logic [IDX_W-1:0]     idx_diff;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    wp_inc;
    logic                 clear;
    logic                 bypass;

    logic                       open_a;
    logic                       close_now;
    logic signed [PW:0]         peak_x;
    logic signed [PW:0]         lvl_x;
    logic signed [PW:0]         pk_max;
    logic signed [PW:0]         pk_sub;
    logic signed [PW-1:0]       peak_upd;
    logic [HOLD_COUNT_BITS-1:0] cc_base;
    logic [HOLD_COUNT_BITS-1:0] cc_upd;
    logic [GW:0]                gain_sum;
    logic [GW-1:0]              gain_upd;

    logic signed [SW-1:0] s2_sample;
    logic [LW-1:0]        s2_mag;
    logic [PROD_W-1:0]    s2_prod;
    logic [PROD_W-1:0]    s2_round;
    logic [GW-1:0]        s2_r;
    logic signed [SW-1:0] s2_gated;
    logic signed [SW-1:0] s2_result;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = p_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    // Configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_thr_reg  <= '0;
            close_thr_reg <= '0;
            attack_reg    <= lng_pkg::UNITY_GAIN;
            release_reg   <= lng_pkg::UNITY_GAIN;
            hold_reg      <= '0;
            decay_reg     <= '0;
            lookahead_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lng_pkg::REG_OPEN_THRESHOLD:  open_thr_reg  <= cfg_data[LW-1:0];
                lng_pkg::REG_CLOSE_THRESHOLD: close_thr_reg <= cfg_data[LW-1:0];
                lng_pkg::REG_ATTACK_STEP:     attack_reg    <= cfg_data[lng_pkg::STEP_W-1:0];
                lng_pkg::REG_RELEASE_STEP:    release_reg   <= cfg_data[lng_pkg::STEP_W-1:0];
                lng_pkg::REG_HOLD_SAMPLES:    hold_reg      <= cfg_data[lng_pkg::HOLD_W-1:0];
                lng_pkg::REG_DECAY_STEP:      decay_reg     <= cfg_data[LW-1:0];
                lng_pkg::REG_LOOKAHEAD:
                    lookahead_reg <= cfg_data[lng_pkg::LOOKAHEAD_W-1:0];
                default: ;
            endcase
        end
    end

    // Item decode and delay-line addressing
    always_comb
    begin
        is_drain = (in_item.cmd == lng_pkg::CMD_DRAIN);
        sample   = in_item.sample_in;
        push_mag = sample[SW-1] ? LW'(-sample) : LW'(sample);
        lvl      = is_drain ? final_mag_reg : push_mag;

        if (LA_W'(lookahead_reg) > LA_W'(LOOKAHEAD_DEPTH - 1))
            la_eff = LA_W'(LOOKAHEAD_DEPTH - 1);
        else
            la_eff = LA_W'(lookahead_reg);

        fill_inc = fill_reg + FILL_W'(1);
        take     = is_drain ? (fill_reg != '0) : (LA_W'(fill_inc) > la_eff);
        clear    = is_drain && (fill_reg <= FILL_W'(1));

        // oldest entry sits fill places behind the write pointer
        wp_ext   = IDX_W'(wp_reg);
        fill_ext = IDX_W'(fill_reg);
        if (wp_ext >= fill_ext)
            idx_diff = wp_ext - fill_ext;
        else
            idx_diff = wp_ext + IDX_W'(LOOKAHEAD_DEPTH) - fill_ext;
        rd_addr = idx_diff[ADDR_W-1:0];

        if (wp_reg == ADDR_W'(LOOKAHEAD_DEPTH - 1))
            wp_inc = '0;
        else
            wp_inc = wp_reg + ADDR_W'(1);

        bypass = (open_thr_reg <= lng_pkg::BYPASS_LEVEL)
              && (close_thr_reg <= lng_pkg::BYPASS_LEVEL);
    end

    // Gate, peak and gain update for the sample leaving the line
    always_comb
    begin
        open_a    = gate_open_reg || (lvl > open_thr_reg);
        peak_x    = {peak_reg[PW-1], peak_reg};
        close_now = open_a && (peak_x < $signed({2'b00, close_thr_reg}));

        lvl_x  = $signed({2'b00, lvl});
        pk_max = (peak_x > lvl_x) ? peak_x : lvl_x;
        pk_sub = pk_max - $signed({2'b00, decay_reg});
        if (pk_sub < $signed(-(PW+1)'(32768)))
            peak_upd = -PW'(32768);
        else
            peak_upd = pk_sub[PW-1:0];

        cc_base  = close_now ? '0 : closed_cnt_reg;
        cc_upd   = cc_base;
        gain_sum = {1'b0, gain_reg} + (GW+1)'(attack_reg);
        gain_upd = gain_reg;

        if (open_a && !close_now)
        begin
            if (gain_sum > (GW+1)'(lng_pkg::UNITY_GAIN))
                gain_upd = lng_pkg::UNITY_GAIN;
            else
                gain_upd = gain_sum[GW-1:0];
        end
        else
        begin
            if (cc_base != '1)
                cc_upd = cc_base + HOLD_COUNT_BITS'(1);
            if (CMP_W'(cc_upd) > CMP_W'(hold_reg))
            begin
                if (GW'(release_reg) < gain_reg)
                    gain_upd = gain_reg - GW'(release_reg);
                else
                    gain_upd = '0;
            end
        end
    end

    always_comb
    begin
        fill_next       = fill_reg;
        wp_next         = wp_reg;
        peak_next       = peak_reg;
        gain_next       = gain_reg;
        closed_cnt_next = closed_cnt_reg;
        gate_open_next  = gate_open_reg;
        final_mag_next  = final_mag_reg;

        if (in_accept)
        begin
            if (!is_drain)
            begin
                wp_next        = wp_inc;
                final_mag_next = push_mag;
                fill_next      = take ? fill_reg : fill_inc;
            end
            else if (take)
            begin
                fill_next = fill_reg - FILL_W'(1);
            end

            if (take && !bypass)
            begin
                peak_next       = peak_upd;
                gain_next       = gain_upd;
                closed_cnt_next = cc_upd;
                gate_open_next  = open_a && !close_now;
            end

            // stream ended: back to the reset state
            if (clear)
            begin
                fill_next       = '0;
                wp_next         = '0;
                peak_next       = '0;
                gain_next       = '0;
                closed_cnt_next = '0;
                gate_open_next  = 1'b0;
                final_mag_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            wp_reg         <= '0;
            peak_reg       <= '0;
            gain_reg       <= '0;
            closed_cnt_reg <= '0;
            gate_open_reg  <= 1'b0;
            final_mag_reg  <= '0;
        end
        else
        begin
            fill_reg       <= fill_next;
            wp_reg         <= wp_next;
            peak_reg       <= peak_next;
            gain_reg       <= gain_next;
            closed_cnt_reg <= closed_cnt_next;
            gate_open_reg  <= gate_open_next;
            final_mag_reg  <= final_mag_next;
        end
    end

    // Delay-line memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (in_accept && !is_drain)
            mem[wp_reg] <= sample;
        if (in_accept)
            rd_data_reg <= mem[rd_addr];
    end

    // Read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (!in_stall)
            p_valid_reg <= in_valid && take;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            p_gain_reg       <= gain_upd;
            p_bypass_reg     <= bypass;
            // the sample just pushed is also the oldest one: forward it
            p_fwd_reg        <= !is_drain && (fill_reg == '0);
            p_fwd_sample_reg <= sample;
            p_last_reg       <= is_drain && (fill_reg == FILL_W'(1));
        end
    end

    // Apply gain, round half away from zero; in bypass the sample passes unchanged
    always_comb
    begin
        s2_sample = p_fwd_reg ? p_fwd_sample_reg : rd_data_reg;
        s2_mag    = s2_sample[SW-1] ? LW'(-s2_sample) : LW'(s2_sample);
        s2_prod   = PROD_W'(s2_mag) * PROD_W'(p_gain_reg);
        s2_round  = s2_prod + PROD_W'(32768);
        s2_r      = s2_round[PROD_W-1:16];
        if (s2_sample[SW-1])
            s2_gated = SW'(-s2_r);
        else if (s2_r > GW'(32767))
            s2_gated = SW'(32767);
        else
            s2_gated = s2_r[SW-1:0];
        s2_result = p_bypass_reg ? s2_sample : s2_gated;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= p_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && p_valid_reg)
        begin
            out_item_reg.sample_out <= s2_result;
            out_item_reg.last       <= p_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

/* rtl/lng_checker.sv */
module lng_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  lng_pkg::out_item_t              out_item
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled output item changed");

    // Output register is empty coming out of reset
    assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
    else $error("output valid right after reset");

    // Input stalls only when the output side is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

    // A result on an empty output comes from an accepted item, through the read stage
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a matching accepted item");

endmodule

bind lookahead_noise_gate lng_checker u_lng_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
